FILE: sv/spoc_pkg.sv
package spoc_pkg;

    localparam int C_NUM_LABELS = 64;
    localparam int C_LBL_W      = 6;
    localparam int C_ROUND_HALF = 8192;
    localparam int C_FRAC_SHIFT = 14;

    typedef logic [2:0]         t_cfg_idx;
    typedef logic [63:0]        t_cfg_data;
    typedef logic [47:0]        t_row;
    typedef logic signed [31:0] t_fix;
    typedef logic signed [47:0] t_prod;

    localparam t_cfg_idx C_REG_ROT_X    = 3'd0;
    localparam t_cfg_idx C_REG_ROT_Y    = 3'd1;
    localparam t_cfg_idx C_REG_ROT_Z    = 3'd2;
    localparam t_cfg_idx C_REG_SHIFT_XY = 3'd3;
    localparam t_cfg_idx C_REG_SHIFT_Z  = 3'd4;
    localparam t_cfg_idx C_REG_HARD     = 3'd5;
    localparam t_cfg_idx C_REG_PROT     = 3'd6;
    localparam t_cfg_idx C_REG_FILTER   = 3'd7;

    localparam t_row        C_ROT_X_RST  = 48'h0000_0000_4000;
    localparam t_row        C_ROT_Y_RST  = 48'h0000_4000_0000;
    localparam t_row        C_ROT_Z_RST  = 48'h4000_0000_0000;
    localparam logic [32:0] C_FILTER_RST = 33'h1_0001_C000;

    localparam t_fix C_FIX_MAX = 32'sh7FFF_FFFF;
    localparam t_fix C_FIX_MIN = 32'sh8000_0000;

endpackage

FILE: sv/spoc_if.sv
interface spoc_pt_if;
    import spoc_pkg::*;
    logic        valid;
    logic        ready;
    t_fix        pos_x;
    t_fix        pos_y;
    t_fix        pos_z;
    logic        position_finite;
    logic [31:0] label;
    logic [15:0] cost;
    logic        cost_finite;
    logic [31:0] observations;
    modport source (output valid, pos_x, pos_y, pos_z, position_finite, label, cost,
                    cost_finite, observations, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, position_finite, label, cost,
                  cost_finite, observations, output ready);
endinterface

interface spoc_res_if;
    import spoc_pkg::*;
    logic valid;
    logic ready;
    t_fix world_x;
    t_fix world_y;
    t_fix world_z;
    logic obstacle;
    logic prot_static;
    modport source (output valid, world_x, world_y, world_z, obstacle, prot_static,
                    input ready);
    modport sink (input valid, world_x, world_y, world_z, obstacle, prot_static,
                  output ready);
endinterface

interface spoc_cfg_if;
    import spoc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/spoc_xf_lane.sv
module spoc_xf_lane (
    input  logic           i_clk,
    input  logic           i_en,
    input  spoc_pkg::t_row i_row,
    input  spoc_pkg::t_fix i_px,
    input  spoc_pkg::t_fix i_py,
    input  spoc_pkg::t_fix i_pz,
    input  spoc_pkg::t_fix i_shift,
    output spoc_pkg::t_fix o_world
);
    import spoc_pkg::*;

    t_prod r_p0, r_p1, r_p2;
    t_prod n_p0, n_p1, n_p2;

    logic signed [49:0] sum;
    logic signed [50:0] rnd;
    logic signed [36:0] quo;
    logic signed [37:0] tot;

    assign n_p0 = $signed(i_row[15:0]) * i_px;
    assign n_p1 = $signed(i_row[31:16]) * i_py;
    assign n_p2 = $signed(i_row[47:32]) * i_pz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
    end

    // Q18.30 sum, round half up to Q16.16, translate, saturate
    assign sum = 50'(r_p0) + 50'(r_p1) + 50'(r_p2);
    assign rnd = 51'(sum) + 51'(C_ROUND_HALF);
    assign quo = rnd[50:C_FRAC_SHIFT];
    assign tot = 38'(quo) + 38'(i_shift);

    always_comb begin
        if (tot[37:31] == {7{tot[37]}}) begin
            o_world = tot[31:0];
        end else if (tot[37]) begin
            o_world = C_FIX_MIN;
        end else begin
            o_world = C_FIX_MAX;
        end
    end

endmodule

FILE: sv/semantic_point_obstacle_classifier_top.sv
// Throughput: one point per cycle while o_res.ready holds; a point passes three
// register stages (input/classify, products, sum/round/saturate) that each hold
// one item, and stall as a chain.
// Reset (synchronous, i_rst_n low) empties all stages and loads the identity
// transform, empty label bitmaps, threshold 0.75, minimum 1, missing cost = obstacle.
module semantic_point_obstacle_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spoc_pt_if.sink     i_pt,
    spoc_res_if.source  o_res,
    spoc_cfg_if.sink    i_cfg
);
    import spoc_pkg::*;

    t_row        r_rot_x, r_rot_y, r_rot_z;
    logic [63:0] r_shift_xy;
    t_fix        r_shift_z;
    logic [63:0] r_hard_mask;
    logic [63:0] r_prot_mask;
    logic [32:0] r_filter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x     <= C_ROT_X_RST;
            r_rot_y     <= C_ROT_Y_RST;
            r_rot_z     <= C_ROT_Z_RST;
            r_shift_xy  <= '0;
            r_shift_z   <= '0;
            r_hard_mask <= '0;
            r_prot_mask <= '0;
            r_filter    <= C_FILTER_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                C_REG_ROT_X:    r_rot_x     <= i_cfg.data[47:0];
                C_REG_ROT_Y:    r_rot_y     <= i_cfg.data[47:0];
                C_REG_ROT_Z:    r_rot_z     <= i_cfg.data[47:0];
                C_REG_SHIFT_XY: r_shift_xy  <= i_cfg.data;
                C_REG_SHIFT_Z:  r_shift_z   <= i_cfg.data[31:0];
                C_REG_HARD:     r_hard_mask <= i_cfg.data;
                C_REG_PROT:     r_prot_mask <= i_cfg.data;
                C_REG_FILTER:   r_filter    <= i_cfg.data[32:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // stage flow
    logic r_s1_vld, r_s2_vld, r_out_vld;
    logic out_free, s2_free, s1_free, accept;

    assign out_free    = !r_out_vld || o_res.ready;
    assign s2_free     = !r_s2_vld || out_free;
    assign s1_free     = !r_s1_vld || s2_free;
    assign i_pt.ready  = s1_free;
    assign accept      = i_pt.valid && s1_free;

    // classification at entry
    logic lbl_ok, hard, prot, keep, obst;

    assign lbl_ok = i_pt.label < 32'(C_NUM_LABELS);
    assign hard   = lbl_ok && r_hard_mask[i_pt.label[C_LBL_W-1:0]];
    assign prot   = lbl_ok && r_prot_mask[i_pt.label[C_LBL_W-1:0]];
    assign keep   = i_pt.position_finite && (i_pt.observations >= 32'(r_filter[31:16]));
    assign obst   = hard || (i_pt.cost_finite ? (i_pt.cost >= r_filter[15:0]) : r_filter[32]);

    t_fix r_s1_x, r_s1_y, r_s1_z;
    logic r_s1_obst, r_s1_prot;
    logic r_s2_obst, r_s2_prot;
    t_fix r_out_x, r_out_y, r_out_z;
    logic r_out_obst, r_out_prot;
    t_fix world_x, world_y, world_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= accept && keep;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_free) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_x    <= i_pt.pos_x;
            r_s1_y    <= i_pt.pos_y;
            r_s1_z    <= i_pt.pos_z;
            r_s1_obst <= obst;
            r_s1_prot <= prot;
        end
        if (s2_free) begin
            r_s2_obst <= r_s1_obst;
            r_s2_prot <= r_s1_prot;
        end
        if (out_free) begin
            r_out_x    <= world_x;
            r_out_y    <= world_y;
            r_out_z    <= world_z;
            r_out_obst <= r_s2_obst;
            r_out_prot <= r_s2_prot;
        end
    end

    spoc_xf_lane u_lane_x (
        .i_clk   (i_clk),
        .i_en    (s2_free),
        .i_row   (r_rot_x),
        .i_px    (r_s1_x),
        .i_py    (r_s1_y),
        .i_pz    (r_s1_z),
        .i_shift (r_shift_xy[31:0]),
        .o_world (world_x)
    );

    spoc_xf_lane u_lane_y (
        .i_clk   (i_clk),
        .i_en    (s2_free),
        .i_row   (r_rot_y),
        .i_px    (r_s1_x),
        .i_py    (r_s1_y),
        .i_pz    (r_s1_z),
        .i_shift (r_shift_xy[63:32]),
        .o_world (world_y)
    );

    spoc_xf_lane u_lane_z (
        .i_clk   (i_clk),
        .i_en    (s2_free),
        .i_row   (r_rot_z),
        .i_px    (r_s1_x),
        .i_py    (r_s1_y),
        .i_pz    (r_s1_z),
        .i_shift (r_shift_z),
        .o_world (world_z)
    );

    assign o_res.valid       = r_out_vld;
    assign o_res.world_x     = r_out_x;
    assign o_res.world_y     = r_out_y;
    assign o_res.world_z     = r_out_z;
    assign o_res.obstacle    = r_out_obst;
    assign o_res.prot_static = r_out_prot;

    a_drop_nonfinite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_pt.position_finite) |=> !r_s1_vld)
        else $error("non-finite point entered the pipeline");

    a_no_lost_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_out_vld && !o_res.ready) |=> r_s2_vld)
        else $error("item lost in stage 2 during output stall");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s2_vld))
        else $error("result appeared without a stage 2 item");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s2_free) |=> (r_s1_vld && $stable(r_s1_x)))
        else $error("stage 1 item changed while stalled");

endmodule
